// File: sv/bsl_pkg.sv
// Shared constants, operation codes and controller/datapath types for the sequential list.
`default_nettype none

package bsl_pkg;

  // Storage geometry
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Transaction field widths
  localparam int KIND_W  = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation codes
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_SEARCH = 3'd0;
  localparam kind_t KIND_REMOVE = 3'd1;
  localparam kind_t KIND_TAIL   = 3'd2;
  localparam kind_t KIND_HEAD   = 3'd3;
  localparam kind_t KIND_SORTED = 3'd4;
  localparam kind_t KIND_SORT   = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch a new transaction and set up the first pass
    logic read;   // fetch the entry at the scan index
    logic exec;   // process the fetched entry, advance the index
    logic wrap;   // end of a pass: final write, count update, result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pass_end;  // scan has nothing more to visit
    logic again;     // sort pass swapped something, another pass follows
  } status_t;

endpackage

`default_nettype wire

// File: sv/bsl_if.sv
// Valid/ready channel interfaces for list requests and list responses.
`default_nettype none

interface bsl_req_if;
  logic                              valid;
  logic                              ready;
  logic [bsl_pkg::KIND_W-1:0]        kind;
  logic signed [bsl_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bsl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [bsl_pkg::POS_W-1:0]   position;
  logic [bsl_pkg::COUNT_W-1:0] count;

  modport source (output valid, output success, output position, output count, input ready);
  modport sink   (input valid, input success, input position, input count, output ready);
endinterface

`default_nettype wire

// File: sv/bsl_datapath.sv
// List datapath: entry memory, scan index, carry register, count and result registers.
`default_nettype none

module bsl_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire bsl_pkg::cmd_t                cmd_i,
  output bsl_pkg::status_t                  status_o,
  input  wire [bsl_pkg::KIND_W-1:0]         kind_i,
  input  wire signed [bsl_pkg::DATA_W-1:0]  value_i,
  input  wire                               cfg_we_i,
  input  wire [bsl_pkg::CAP_W-1:0]          cfg_wdata_i,
  output logic                              success_o,
  output logic [bsl_pkg::POS_W-1:0]         position_o,
  output logic [bsl_pkg::COUNT_W-1:0]       count_o
);

  localparam int IDX_W = bsl_pkg::IDX_W;
  localparam int CNT_W = bsl_pkg::CNT_W;
  localparam int DW    = bsl_pkg::DATA_W;
  localparam int CAP_W = bsl_pkg::CAP_W;

  // Entry store
  logic [DW-1:0] mem [bsl_pkg::DEPTH];
  logic [DW-1:0] rdata_q;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CAP_W-1:0]     cap_q;
  bsl_pkg::kind_t       kind_q;
  logic signed [DW-1:0] value_q;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [DW-1:0]        carry_q, carry_d;
  logic                 flag_q, flag_d;
  logic                 skip_q;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic                 success_q, success_d;
  logic [IDX_W-1:0]     position_q, position_d;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [DW-1:0]        wdata;
  logic                 full;
  logic                 is_insert_in;
  logic                 place;
  logic [IDX_W-1:0]     idx_lo;
  logic [IDX_W-1:0]     idx_m1;
  logic [IDX_W-1:0]     cnt_lo;
  logic [IDX_W-1:0]     cnt_m1;

  assign idx_lo = idx_q[IDX_W-1:0];
  assign idx_m1 = idx_lo - IDX_W'(1);
  assign cnt_lo = count_q[IDX_W-1:0];
  assign cnt_m1 = cnt_lo - IDX_W'(1);

  // List is full at the smaller of capacity and storage depth
  assign full = (count_q >= CNT_W'(bsl_pkg::DEPTH)) ||
                ({{CAP_W{1'b0}}, count_q} >= {{CNT_W{1'b0}}, cap_q});

  assign is_insert_in = (kind_i == bsl_pkg::KIND_TAIL) || (kind_i == bsl_pkg::KIND_HEAD) ||
                        (kind_i == bsl_pkg::KIND_SORTED);

  // Insert point: head always, sorted before the first larger entry
  assign place = (kind_q == bsl_pkg::KIND_HEAD) ||
                 ((kind_q == bsl_pkg::KIND_SORTED) && ($signed(rdata_q) > value_q));

  // Status back to the controller
  assign status_o.pass_end = skip_q || (idx_q == count_q) ||
                             ((kind_q == bsl_pkg::KIND_SEARCH) && flag_q);
  assign status_o.again    = (kind_q == bsl_pkg::KIND_SORT) && !skip_q && flag_q;

  // Per-step datapath behavior
  always_comb begin
    we         = 1'b0;
    waddr      = idx_lo;
    wdata      = carry_q;
    count_d    = count_q;
    idx_d      = idx_q;
    carry_d    = carry_q;
    flag_d     = flag_q;
    pos_d      = pos_q;
    success_d  = success_q;
    position_d = position_q;

    if (cmd_i.exec) begin
      idx_d = idx_q + CNT_W'(1);
      case (kind_q)
        bsl_pkg::KIND_SEARCH: begin
          if (rdata_q == value_q) begin
            flag_d = 1'b1;
            pos_d  = idx_lo;
          end
        end
        bsl_pkg::KIND_REMOVE: begin
          // after the match every entry moves down by one
          if (flag_q) begin
            we    = 1'b1;
            waddr = idx_m1;
            wdata = rdata_q;
          end else if (rdata_q == value_q) begin
            flag_d = 1'b1;
          end
        end
        bsl_pkg::KIND_TAIL, bsl_pkg::KIND_HEAD, bsl_pkg::KIND_SORTED: begin
          // from the insert point on, each slot takes the carried value
          if (flag_q || place) begin
            we      = 1'b1;
            waddr   = idx_lo;
            wdata   = carry_q;
            carry_d = rdata_q;
            flag_d  = 1'b1;
          end
        end
        bsl_pkg::KIND_SORT: begin
          // bubble pass: carry the largest value seen so far upward
          if (idx_q == '0) begin
            carry_d = rdata_q;
          end else if ($signed(carry_q) > $signed(rdata_q)) begin
            we     = 1'b1;
            waddr  = idx_m1;
            wdata  = rdata_q;
            flag_d = 1'b1;
          end else begin
            we      = 1'b1;
            waddr   = idx_m1;
            wdata   = carry_q;
            carry_d = rdata_q;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.wrap) begin
      position_d = '0;
      success_d  = 1'b0;
      if (skip_q) begin
        success_d = (kind_q == bsl_pkg::KIND_SORT);
      end else begin
        case (kind_q)
          bsl_pkg::KIND_SEARCH: begin
            success_d  = flag_q;
            position_d = flag_q ? pos_q : '0;
          end
          bsl_pkg::KIND_REMOVE: begin
            success_d = flag_q;
            if (flag_q) begin
              count_d = count_q - CNT_W'(1);
            end
          end
          bsl_pkg::KIND_TAIL, bsl_pkg::KIND_HEAD, bsl_pkg::KIND_SORTED: begin
            we        = 1'b1;
            waddr     = cnt_lo;
            wdata     = carry_q;
            count_d   = count_q + CNT_W'(1);
            success_d = 1'b1;
          end
          bsl_pkg::KIND_SORT: begin
            we    = 1'b1;
            waddr = cnt_m1;
            wdata = carry_q;
            if (flag_q) begin
              // another pass; result registers keep their value
              idx_d      = '0;
              flag_d     = 1'b0;
              success_d  = success_q;
              position_d = position_q;
            end else begin
              success_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[idx_lo];
    end
  end

  // Transaction operands and scan state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
      carry_q <= value_i;
      flag_q  <= 1'b0;
      pos_q   <= '0;
      idx_q   <= (kind_i == bsl_pkg::KIND_TAIL) ? count_q : '0;
    end else begin
      carry_q <= carry_d;
      flag_q  <= flag_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
    end
    success_q  <= success_d;
    position_q <= position_d;
  end

  // Control state: count, capacity, skip
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= bsl_pkg::CAP_RESET;
      skip_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        // refused insert, trivial sort or unused code: no scan at all
        skip_q <= (is_insert_in && full) ||
                  ((kind_i == bsl_pkg::KIND_SORT) && (count_q < CNT_W'(2))) ||
                  (kind_i > bsl_pkg::KIND_SORT);
      end
    end
  end

  assign success_o  = success_q;
  assign position_o = bsl_pkg::POS_W'(position_q);
  assign count_o    = bsl_pkg::COUNT_W'(count_q);

endmodule

`default_nettype wire

// File: sv/bsl_ctrl.sv
// List controller: sequences scan passes and owns the response valid flag.
`default_nettype none

module bsl_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  input  wire bsl_pkg::status_t   status_i,
  output bsl_pkg::cmd_t           cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   finish;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    cmd_o  = '0;
    finish = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        if (status_i.pass_end) begin
          if (status_i.again) begin
            cmd_o.wrap = 1'b1;
          end else if (out_free) begin
            cmd_o.wrap = 1'b1;
            finish     = 1'b1;
          end
        end else begin
          cmd_o.read = 1'b1;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end else if (!status_i.pass_end) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_SCAN;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/bounded_sequential_list_top.sv
// Top level of the bounded sequential list: controller, datapath and channel hookup.
//
// Usage:
//   req_i carries one transaction per operation: kind (search, remove, insert
//   tail, insert head, insert sorted, sort) and a signed 32-bit value.
//   rsp_o returns exactly one transaction per request: success, position of
//   the first match (search only) and the entry count after the operation.
//   cfg_we_i/cfg_wdata_i write the capacity limit; write only while idle.
// Timing:
//   One request is worked on at a time. The memory, with one write port
//   and one registered read port, is walked one entry at a time (read,
//   then process/write-back). Search, remove, insert head/sorted scan the
//   stored entries; search ends at the first match. Insert tail and
//   refused inserts scan no entries. Sort runs bubble passes until one
//   pass makes no swap.
// Reset: count clears to zero, capacity returns to 64, no response pending.
//   Entry storage is not cleared; only written entries are ever read.
// Back-pressure: a finished response waits in the output register; the
//   next request is still taken and scanned, and stalls only at its end.
`default_nettype none

module bounded_sequential_list_top (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  bsl_req_if.sink                    req_i,
  bsl_rsp_if.source                  rsp_o,
  input  wire                        cfg_we_i,
  input  wire [bsl_pkg::CAP_W-1:0]   cfg_wdata_i
);

  bsl_pkg::cmd_t    cmd;
  bsl_pkg::status_t status;

  // Sequencer
  bsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and operation logic
  bsl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (req_i.kind),
    .value_i     (req_i.value),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .success_o   (rsp_o.success),
    .position_o  (rsp_o.position),
    .count_o     (rsp_o.count)
  );

endmodule

`default_nettype wire
